// ===== src/lpmd_pkg.sv =====
// Shared types and constants for the length-prefixed message deframer.
// Holds the result kind and error codes, the header layout and register reset values.
// Depends on nothing.
package lpmd_pkg;

    localparam int unsigned HEADER_BYTES = 5;
    localparam int unsigned HDR_IDX_W    = 3;

    localparam logic [7:0]  FLAG_NONE       = 8'h00;
    localparam logic [7:0]  FLAG_COMPRESSED = 8'h01;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4194304;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_COMPRESSED = 2'd0,
        ERR_BAD_FLAG   = 2'd1,
        ERR_OVERSIZE   = 2'd2
    } err_t;

endpackage

// ===== src/length_prefixed_message_deframer.sv =====
// Top level of the length-prefixed message deframer.
// Holds the input register, the header and payload tracking and the result register.
// Depends on lpmd_pkg.

// The block takes one byte per transaction and accepts a new byte in every cycle while
// results are taken. A byte passes an input register and then header parsing and length
// checking into the result register; a stall on the output holds it in the input
// register. Each frame is a flag byte and a big-endian 32-bit length followed by the
// payload; payload bytes leave one per transaction, with tlast on the final one, and
// an empty message gives one result of its own. A compressed or bad flag, or an
// oversized length gives one error result, after which all input is taken and dropped
// until reset. The maximum length may be written only while no transaction is in flight.
module length_prefixed_message_deframer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,    // max_payload_bytes

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic        m_axis_tlast,   // last_of_message
    output logic [3:0]  m_axis_tuser    // [1:0] kind, [3:2] error_kind
);

    localparam int unsigned HW = lpmd_pkg::HDR_IDX_W;
    localparam logic [HW-1:0] HDR_LAST_IDX = HW'(lpmd_pkg::HEADER_BYTES - 1);

    logic [31:0]   max_len_reg;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;

    logic [HW-1:0] hdr_idx_reg, hdr_idx_next;
    logic [7:0]    flag_reg, flag_next;
    logic [31:0]   len_reg, len_next;
    logic [31:0]   remain_reg, remain_next;
    logic          in_payload_reg, in_payload_next;
    logic          failed_reg, failed_next;

    logic              out_valid_reg;
    lpmd_pkg::kind_t   kind_reg, kind_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    lpmd_pkg::err_t    err_reg, err_next;
    logic              produce;

    logic          advance;
    logic [31:0]   len_shift;
    logic [31:0]   remain_dec;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign len_shift  = {len_reg[23:0], in_byte_reg};
    assign remain_dec = remain_reg - 32'd1;

    always_comb
    begin
        hdr_idx_next    = hdr_idx_reg;
        flag_next       = flag_reg;
        len_next        = len_reg;
        remain_next     = remain_reg;
        in_payload_next = in_payload_reg;
        failed_next     = failed_reg;
        produce         = 1'b0;
        kind_next       = lpmd_pkg::KIND_PAYLOAD;
        byte_next       = 8'h00;
        last_next       = 1'b0;
        err_next        = lpmd_pkg::ERR_COMPRESSED;

        if (failed_reg)
        begin
            produce = 1'b0;
        end
        else if (in_payload_reg)
        begin
            remain_next = remain_dec;
            produce     = 1'b1;
            byte_next   = in_byte_reg;
            last_next   = (remain_dec == 32'd0);
            if (remain_dec == 32'd0)
            begin
                in_payload_next = 1'b0;
            end
        end
        else if (hdr_idx_reg == '0)
        begin
            flag_next    = in_byte_reg;
            len_next     = 32'd0;
            hdr_idx_next = HW'(1);
        end
        else
        begin
            len_next = len_shift;
            if (hdr_idx_reg != HDR_LAST_IDX)
            begin
                hdr_idx_next = hdr_idx_reg + HW'(1);
            end
            else
            begin
                hdr_idx_next = '0;
                priority if (flag_reg == lpmd_pkg::FLAG_COMPRESSED)
                begin
                    failed_next = 1'b1;
                    produce     = 1'b1;
                    kind_next   = lpmd_pkg::KIND_ERROR;
                    err_next    = lpmd_pkg::ERR_COMPRESSED;
                end
                else if (flag_reg != lpmd_pkg::FLAG_NONE)
                begin
                    failed_next = 1'b1;
                    produce     = 1'b1;
                    kind_next   = lpmd_pkg::KIND_ERROR;
                    err_next    = lpmd_pkg::ERR_BAD_FLAG;
                end
                else if (len_shift > max_len_reg)
                begin
                    failed_next = 1'b1;
                    produce     = 1'b1;
                    kind_next   = lpmd_pkg::KIND_ERROR;
                    err_next    = lpmd_pkg::ERR_OVERSIZE;
                end
                else if (len_shift == 32'd0)
                begin
                    produce   = 1'b1;
                    kind_next = lpmd_pkg::KIND_EMPTY;
                    last_next = 1'b1;
                end
                else
                begin
                    remain_next     = len_shift;
                    in_payload_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= lpmd_pkg::MAX_PAYLOAD_RESET;
            in_valid_reg   <= 1'b0;
            hdr_idx_reg    <= '0;
            flag_reg       <= 8'h00;
            len_reg        <= 32'd0;
            remain_reg     <= 32'd0;
            in_payload_reg <= 1'b0;
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                hdr_idx_reg    <= hdr_idx_next;
                flag_reg       <= flag_next;
                len_reg        <= len_next;
                remain_reg     <= remain_next;
                in_payload_reg <= in_payload_next;
                failed_reg     <= failed_next;
                out_valid_reg  <= produce;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = byte_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = {err_reg, kind_reg};

`ifndef SYNTHESIS
    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |=> failed_reg)
        else $error("Failure state was left without reset.");

    a_payload_no_header: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (hdr_idx_reg == '0) && (remain_reg != 32'd0) && !failed_reg)
        else $error("Payload tracking overlaps header parsing or has no bytes left.");

    a_error_sets_failed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == lpmd_pkg::KIND_ERROR)) |-> failed_reg)
        else $error("Error result without the block entering the failed state.");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == lpmd_pkg::KIND_EMPTY)) |-> last_reg)
        else $error("Empty message result without tlast.");

    a_no_result_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && failed_reg) |=> !out_valid_reg)
        else $error("Result produced for a transaction taken after failure.");
`endif

endmodule
